@@ rtl/core/pdfm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_pkg
// shared widths, constants and the measurement job type of the pwm meter
// ----------------------------------------------------------------------------
package pdfm_pkg;

  localparam int COUNT_W     = 32;
  localparam int CLK_W       = 27;
  localparam int DUTY_W      = 7;
  localparam int PROD_W      = COUNT_W + DUTY_W;
  localparam int DUTY_STEPS  = DUTY_W;
  localparam int FREQ_STEPS  = CLK_W;
  localparam int STEP_W      = $clog2(FREQ_STEPS);
  localparam int CMP_W       = (COUNT_W > CLK_W + 1) ? COUNT_W : CLK_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CLK_W-1:0]   CLOCK_RESET = CLK_W'(8000000);

  typedef struct packed {
    logic               ovf;
    logic [COUNT_W-1:0] high;
    logic [COUNT_W-1:0] period;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/core/pdfm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_front
// edge detection and tick counting, one sample per transaction
// ----------------------------------------------------------------------------
module pdfm_front import pdfm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_pin_level,
  input  wire logic q_full,
  output logic      q_push,
  output job_t      q_job
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               prev_r, prev_nxt;
  logic [COUNT_W-1:0] period_r, period_nxt;
  logic [COUNT_W-1:0] high_r, high_nxt;
  logic [COUNT_W-1:0] period_inc;
  logic               accept;
  logic               rising;
  logic               falling;
  logic               counting;

  assign in_stall   = q_full;
  assign accept     = in_valid & ~q_full;
  assign rising     = ~prev_r & in_pin_level;
  assign falling    = prev_r & ~in_pin_level;
  assign counting   = (phase_r == PH_HIGH) || (phase_r == PH_LOW);
  assign period_inc = period_r + COUNT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    period_nxt = period_r;
    high_nxt   = high_r;
    q_push     = 1'b0;
    q_job      = '0;
    if (accept) begin
      prev_nxt = in_pin_level;
      if (counting && period_r == COUNT_MAX) begin
        // counter range passed, push an overflow job and drop this measurement
        q_push     = 1'b1;
        q_job.ovf  = 1'b1;
        phase_nxt  = PH_WAIT;
        period_nxt = '0;
        high_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_HIGH: begin
            period_nxt = period_inc;
            if (falling) begin
              high_nxt  = period_inc;
              phase_nxt = PH_LOW;
            end
          end
          PH_LOW: begin
            if (rising) begin
              q_push       = 1'b1;
              q_job.high   = high_r;
              q_job.period = period_inc;
              phase_nxt    = PH_HIGH;
              period_nxt   = '0;
              high_nxt     = '0;
            end else begin
              period_nxt = period_inc;
            end
          end
          PH_WAIT: begin
            if (rising) begin
              phase_nxt  = PH_HIGH;
              period_nxt = '0;
              high_nxt   = '0;
            end
          end
          default: begin
            phase_nxt  = PH_WAIT;
            period_nxt = '0;
            high_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      prev_r   <= 1'b1;
      period_r <= '0;
      high_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      prev_r   <= prev_nxt;
      period_r <= period_nxt;
      high_r   <= high_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pdfm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_queue
// short job queue between the counting front and the divider back
// ----------------------------------------------------------------------------
module pdfm_queue import pdfm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pdfm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pdfm_back
// bit-serial division of duty and frequency, holds the result transaction
// ----------------------------------------------------------------------------
module pdfm_back import pdfm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  job_t                  q_job,
  output logic                  q_pop,
  input  wire logic [CLK_W-1:0] clock_hz,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [DUTY_W-1:0]     out_duty_percent,
  output logic [CLK_W-1:0]      out_frequency_hz,
  output logic                  out_overflow
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FREQ_STEPS - 1);

  bstate_t            state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               zero_r, zero_nxt;
  logic [COUNT_W-1:0] den_r, den_nxt;
  logic [PROD_W-1:0]  drem_r, drem_nxt;
  logic [PROD_W-1:0]  dsh_r, dsh_nxt;
  logic [DUTY_W-1:0]  dq_r, dq_nxt;
  logic [CLK_W-1:0]   fdiv_r, fdiv_nxt;
  logic [CLK_W-1:0]   frem_r, frem_nxt;
  logic [CLK_W-1:0]   fq_r, fq_nxt;
  logic [PROD_W-1:0]  high_ext;
  logic [PROD_W-1:0]  prod;
  logic               dge;
  logic [CLK_W:0]     ftrial;
  logic [CMP_W-1:0]   ftrial_ext;
  logic [CMP_W-1:0]   den_ext;
  logic               fge;

  // high * 100 as shifts and adds
  assign high_ext   = PROD_W'(q_job.high);
  assign prod       = (high_ext << 6) + (high_ext << 5) + (high_ext << 2);
  assign dge        = (drem_r >= dsh_r);
  assign ftrial     = {frem_r, fdiv_r[CLK_W-1]};
  assign ftrial_ext = CMP_W'(ftrial);
  assign den_ext    = CMP_W'(den_r);
  assign fge        = (ftrial_ext >= den_ext);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    zero_nxt  = zero_r;
    den_nxt   = den_r;
    drem_nxt  = drem_r;
    dsh_nxt   = dsh_r;
    dq_nxt    = dq_r;
    fdiv_nxt  = fdiv_r;
    frem_nxt  = frem_r;
    fq_nxt    = fq_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          ovf_nxt  = q_job.ovf;
          zero_nxt = (q_job.period == '0);
          den_nxt  = q_job.period;
          drem_nxt = prod;
          dsh_nxt  = PROD_W'(q_job.period) << (DUTY_STEPS - 1);
          dq_nxt   = '0;
          fdiv_nxt = clock_hz;
          frem_nxt = '0;
          fq_nxt   = '0;
          cnt_nxt  = '0;
          state_nxt = q_job.ovf ? B_OUT : B_RUN;
        end
      end
      B_RUN: begin
        if (cnt_r < STEP_W'(DUTY_STEPS)) begin
          if (dge) begin
            drem_nxt = drem_r - dsh_r;
          end
          dq_nxt  = {dq_r[DUTY_W-2:0], dge};
          dsh_nxt = dsh_r >> 1;
        end
        frem_nxt = fge ? CLK_W'(ftrial_ext - den_ext) : ftrial[CLK_W-1:0];
        fdiv_nxt = fdiv_r << 1;
        fq_nxt   = {fq_r[CLK_W-2:0], fge};
        cnt_nxt  = cnt_r + STEP_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_stall) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r  <= ovf_nxt;
    zero_r <= zero_nxt;
    den_r  <= den_nxt;
    drem_r <= drem_nxt;
    dsh_r  <= dsh_nxt;
    dq_r   <= dq_nxt;
    fdiv_r <= fdiv_nxt;
    frem_r <= frem_nxt;
    fq_r   <= fq_nxt;
  end

  assign out_valid        = (state_r == B_OUT);
  assign out_overflow     = ovf_r;
  assign out_duty_percent = (ovf_r || zero_r) ? '0 : dq_r;
  assign out_frequency_hz = (ovf_r || zero_r) ? '0 : fq_r;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |-> (cnt_r <= LAST_STEP))
    else $error("division step count out of range");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN && cnt_r == LAST_STEP) |=> (state_r == B_OUT))
    else $error("division did not finish on its last step");
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |-> (out_duty_percent < DUTY_W'(100)))
    else $error("duty result above 99 percent");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pwm_duty_frequency_meter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter
// measures high time and period of a sampled pwm line, reports duty and rate
// ----------------------------------------------------------------------------
// in_pin_level carries one sample of the pwm line per timer tick, one
// transaction per cycle while the job queue has room. After a rising edge the
// block counts ticks to the falling edge and on to the next rising edge; that
// closing edge yields one result transaction and opens the next measurement.
// out_duty_percent = high * 100 / period, out_frequency_hz = cfg clock / period.
// A period that passes the counter range gives out_overflow with zero fields.
// cfg_wr_en/cfg_wr_data load the timer clock in hertz; the user must write it
// only while idle, the block does not enforce this. Jobs pass the two-entry
// queue of finished measurements and the 27-step bit-serial frequency divider
// (one quotient bit a cycle), which takes one job at a time. Samples are taken
// one per cycle while the queue has room.
// While out_stall is high the result holds; the front keeps sampling until
// the queue is full, then raises in_stall.
// Reset: line taken as high, waiting for a rising edge, clock 8000000 hz.
// ----------------------------------------------------------------------------
module pwm_duty_frequency_meter import pdfm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_pin_level,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [DUTY_W-1:0]     out_duty_percent,
  output logic [CLK_W-1:0]      out_frequency_hz,
  output logic                  out_overflow,
  input  wire logic             cfg_wr_en,
  input  wire logic [CLK_W-1:0] cfg_wr_data
);

  logic [CLK_W-1:0] clock_hz_r;
  logic             q_push;
  job_t             q_push_job;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  job_t             q_head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  pdfm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pin_level (in_pin_level),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_push_job)
  );

  pdfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head_job)
  );

  pdfm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (q_head_job),
    .q_pop            (q_pop),
    .clock_hz         (clock_hz_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty_percent (out_duty_percent),
    .out_frequency_hz (out_frequency_hz),
    .out_overflow     (out_overflow)
  );

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pwm duty and frequency meter
// ----------------------------------------------------------------------------
// Pin samples are sent over the input channel, one transaction per timer
// tick, mostly as well-formed pulse trains of random high and low length with
// some raw noise mixed in. A model of the edge tracker and the tick counters
// runs on every accepted sample and queues the duty and frequency each
// closing rising edge should produce. Every result transaction is checked
// against the oldest queued measurement. The timer clock register is changed
// between phases, only with the meter drained, covering zero, one, the top of
// the range and the full register width. Sender gaps and receiver stalls are
// drawn per transaction, with some phases running without any idling.
// ----------------------------------------------------------------------------
module tb;
  import pdfm_pkg::*;

  localparam int          WATCHDOG_CYCLES = 2000;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          MAX_ERR_SHOWN   = 10;
  localparam logic [CLK_W-1:0] CLOCK_TOP  = CLK_W'(100000000);
  localparam logic [CLK_W-1:0] CLOCK_FULL = {CLK_W{1'b1}};

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [CLK_W-1:0]  freq;
    logic              ovf;
  } meas_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_pin_level = 1'b0;
  logic              out_stall    = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic [CLK_W-1:0]  cfg_wr_data  = '0;
  logic              in_stall;
  logic              out_valid;
  logic [DUTY_W-1:0] out_duty_percent;
  logic [CLK_W-1:0]  out_frequency_hz;
  logic              out_overflow;

  // meter model state
  logic               prev_lvl;
  phase_t             phase;
  logic [COUNT_W-1:0] period_cnt;
  logic [COUNT_W-1:0] high_cnt;
  logic [CLK_W-1:0]   clock_hz;

  meas_t meas_q[$];
  bit    idle_on;
  int    rx_hold;
  int    err_cnt;
  int    sample_cnt;
  int    meas_cnt;
  int    clock_cnt;
  int    quiet_cycles;

  pwm_duty_frequency_meter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_level     (in_pin_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty_percent (out_duty_percent),
    .out_frequency_hz (out_frequency_hz),
    .out_overflow     (out_overflow),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void reset_meter_model();
    prev_lvl   = 1'b1;
    phase      = PH_WAIT;
    period_cnt = '0;
    high_cnt   = '0;
    clock_hz   = CLOCK_RESET;
  endfunction

  function automatic void track_pin_sample(input logic lvl);
    logic  rise;
    logic  fall;
    meas_t m;
    rise     = !prev_lvl && lvl;
    fall     = prev_lvl && !lvl;
    prev_lvl = lvl;
    if (phase == PH_HIGH || phase == PH_LOW) begin
      if (period_cnt >= COUNT_MAX) begin
        phase      = PH_WAIT;
        period_cnt = '0;
        high_cnt   = '0;
        m          = '{duty: '0, freq: '0, ovf: 1'b1};
        meas_q.push_back(m);
        return;
      end
      period_cnt++;
    end
    case (phase)
      PH_HIGH: begin
        if (fall) begin
          high_cnt = period_cnt;
          phase    = PH_LOW;
        end
      end
      PH_LOW: begin
        if (rise) begin
          m = '{duty: '0, freq: '0, ovf: 1'b0};
          if (period_cnt != 0) begin
            m.duty = DUTY_W'(64'(high_cnt) * 64'd100 / 64'(period_cnt));
            m.freq = CLK_W'(64'(clock_hz) / 64'(period_cnt));
          end
          meas_q.push_back(m);
          phase      = PH_HIGH;
          period_cnt = '0;
          high_cnt   = '0;
        end
      end
      default: begin
        if (rise) begin
          phase      = PH_HIGH;
          period_cnt = '0;
          high_cnt   = '0;
        end
      end
    endcase
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < MAX_ERR_SHOWN) $display("ERROR: %s", msg);
    err_cnt++;
  endfunction

  function automatic int draw_wait();
    return idle_on ? $urandom_range(11, 0) : 0;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    meas_t m;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        meas_cnt++;
        if (meas_q.size() == 0) begin
          note_error($sformatf("unexpected result duty %0d freq %0d ovf %0d",
                               out_duty_percent, out_frequency_hz, out_overflow));
        end else begin
          m = meas_q.pop_front();
          if (out_duty_percent !== m.duty || out_frequency_hz !== m.freq ||
              out_overflow !== m.ovf)
            note_error($sformatf(
              "result %0d: expected duty %0d freq %0d ovf %0d, got %0d %0d %0d",
              meas_cnt, m.duty, m.freq, m.ovf,
              out_duty_percent, out_frequency_hz, out_overflow));
        end
        rx_hold = draw_wait();
      end else if (out_valid && rx_hold != 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout with %0d measurements outstanding", meas_q.size());
        $display("pwm_duty_frequency_meter: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic lvl);
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= lvl;
    do @(posedge clk); while (in_stall);
    track_pin_sample(lvl);
    sample_cnt++;
  endtask

  task automatic send_pulse(input int hi, input int lo);
    repeat (hi) send_sample(1'b1);
    repeat (lo) send_sample(1'b0);
  endtask

  task automatic drain_meter();
    in_valid <= 1'b0;
    while (meas_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timer_clock(input logic [CLK_W-1:0] hz);
    drain_meter();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clock_hz = hz;
    clock_cnt++;
  endtask

  task automatic send_random_train(input int n_items);
    int target;
    int pick;
    target = sample_cnt + n_items;
    while (sample_cnt < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 8)
        repeat ($urandom_range(8, 1)) send_sample(1'($urandom_range(1, 0)));
      else if (pick < 12)
        send_pulse($urandom_range(100, 20), $urandom_range(100, 20));
      else
        send_pulse($urandom_range(12, 1), $urandom_range(12, 1));
    end
  endtask

  // line high at reset is no edge, a falling edge while waiting is ignored
  task automatic test_reset_line_state();
    idle_on = 1'b1;
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_pulse(1, 1);
  endtask

  // shortest period, duty of zero and duty of 99
  task automatic test_duty_extremes();
    send_pulse(1, 100);
    send_pulse(99, 1);
    send_pulse(1, 1);
    send_pulse(2, 3);
  endtask

  task automatic test_clock_extremes();
    logic [CLK_W-1:0] hz_list[4];
    hz_list = '{CLK_W'(0), CLK_W'(1), CLOCK_TOP, CLOCK_FULL};
    foreach (hz_list[i]) begin
      write_timer_clock(hz_list[i]);
      idle_on = ($urandom_range(3, 0) != 0);
      send_pulse(1, 1);
      send_pulse(1, 1);
      send_pulse(2, 3);
      send_random_train(40);
    end
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      write_timer_clock(CLK_W'($urandom_range(100000000, 1)));
      idle_on = ($urandom_range(3, 0) != 0);
      send_random_train(180);
    end
    write_timer_clock(CLOCK_RESET);
    idle_on = 1'b1;
    send_random_train(180);
  endtask

  initial begin
    reset_meter_model();
    err_cnt    = 0;
    sample_cnt = 0;
    meas_cnt   = 0;
    clock_cnt  = 0;
    idle_on    = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_line_state();
    test_duty_extremes();
    test_clock_extremes();
    test_random_traffic();
    drain_meter();

    if (meas_q.size() != 0) note_error("measurements left unchecked");
    $display("sent %0d pin samples, checked %0d measurements", sample_cnt, meas_cnt);
    $display("timer clock written %0d times, %0d mismatches", clock_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("pwm_duty_frequency_meter: match");
    end else begin
      $display("pwm_duty_frequency_meter: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/pdfm_pkg.sv
rtl/core/pdfm_front.sv
rtl/core/pdfm_queue.sv
rtl/core/pdfm_back.sv
rtl/core/pwm_duty_frequency_meter.sv
verif/tb.sv
